/* hw/rtl/nfa_wa_pkg.sv */
// shared types, constants and helpers for the nfa word acceptor
package nfa_wa_pkg;

   // automaton size
   localparam int NUM_STATES  = 16;
   localparam int SYMBOL_BITS = 8;

   // fixed field widths of the request, response and csr port
   localparam int MODE_W      = 2;
   localparam int STATE_W     = 4;
   localparam int SYMBOL_W    = 8;
   localparam int FIELD_SET_W = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // derived sizes
   localparam int STATE_IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
   localparam int ROW_W       = NUM_STATES * NUM_STATES;
   localparam int ROW_IDX_W   = $clog2(ROW_W);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FEED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK = 2'd1;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_FEED,
      OP_END
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [STATE_W-1:0]  from_state;
      logic [STATE_W-1:0]  to_state;
      logic [SYMBOL_W-1:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic                   accepted;
      logic [FIELD_SET_W-1:0] final_active;
   } rsp_payload_type;

   typedef struct packed {
      op_type                 op;
      logic [SYMBOL_BITS-1:0] sym;
      logic [STATE_IDX_W-1:0] from_idx;
      logic [STATE_IDX_W-1:0] to_idx;
   } cmd_type;

   typedef struct packed {
      logic [STATE_W-1:0]     start_state;
      logic [FIELD_SET_W-1:0] accept_mask;
   } cfg_type;

   // low bits of a state set as seen on the 16-bit fields
   function automatic logic [FIELD_SET_W-1:0] field_view(input logic [NUM_STATES-1:0] set);
      logic [63:0] wide;
      wide = 64'(set);
      return wide[FIELD_SET_W-1:0];
   endfunction

endpackage

/* hw/rtl/nfa_wa_ram.sv */
// generic single write, single read ram with registered read data
module nfa_wa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nfa_wa_front.sv */
// request intake: classifies requests into back-end commands, drops no-op requests
module nfa_wa_front import nfa_wa_pkg::*; (
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            push_valid,
   input  logic            push_ready,
   output cmd_type         push_data
);

   logic keep;
   logic edge_in_range;

   assign edge_in_range = (int'(req_data.from_state) < NUM_STATES) &&
                          (int'(req_data.to_state) < NUM_STATES);

   always_comb begin
      keep         = 1'b0;
      push_data.op = OP_FEED;
      unique case (req_data.mode)
         MODE_ADD: begin
            keep         = edge_in_range;
            push_data.op = OP_ADD;
         end
         MODE_FEED: begin
            keep         = 1'b1;
            push_data.op = OP_FEED;
         end
         MODE_END: begin
            keep         = 1'b1;
            push_data.op = OP_END;
         end
         default: begin
            keep         = 1'b0;
            push_data.op = OP_FEED;
         end
      endcase
      push_data.sym      = req_data.symbol[SYMBOL_BITS-1:0];
      push_data.from_idx = STATE_IDX_W'(req_data.from_state);
      push_data.to_idx   = STATE_IDX_W'(req_data.to_state);
   end

   // dropped requests are taken whenever the queue could take one
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

/* hw/rtl/nfa_wa_queue.sv */
// short command fifo between the front and back end
module nfa_wa_queue import nfa_wa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (int'(count_ff) < QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = do_pop ? QUEUE_PTR_W'(int'(head_ff) + 1) : head_ff;
      tail_in  = do_push ? QUEUE_PTR_W'(int'(tail_ff) + 1) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/nfa_wa_back.sv */
// back end: edge-row memory, subset step, end-of-word result register
module nfa_wa_back import nfa_wa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            cmd_valid,
   output logic            cmd_ready,
   input  cmd_type         cmd_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   // per-symbol row valid flags, a row never written reads as no edges
   logic [SYM_COUNT-1:0]   row_valid_ff, row_valid_in;

   // execute stage
   logic                   b_valid_ff, b_valid_in;
   cmd_type                b_cmd_ff;
   logic                   b_row_valid_ff;

   // write of the previous cycle, forwarded over the ram read
   logic                   lw_valid_ff;
   logic [SYMBOL_BITS-1:0] lw_addr_ff;
   logic [ROW_W-1:0]       lw_data_ff;

   logic [NUM_STATES-1:0]  active_ff, active_in;
   logic                   fresh_ff, fresh_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff;

   logic [ROW_W-1:0]       ram_rd_data;
   logic [ROW_W-1:0]       row;
   logic [ROW_W-1:0]       wr_row;
   logic [ROW_IDX_W-1:0]   bit_idx;
   logic [NUM_STATES-1:0]  init_set;
   logic [NUM_STATES-1:0]  cur_set;
   logic [NUM_STATES-1:0]  next_set;
   logic [FIELD_SET_W-1:0] cur_view;
   logic                   stall;
   logic                   issue;
   logic                   fire;
   logic                   wr_en;
   logic                   load_rsp;

   assign stall     = b_valid_ff && (b_cmd_ff.op == OP_END) && rsp_valid_ff && !rsp_ready;
   assign cmd_ready = !stall;
   assign issue     = cmd_valid && cmd_ready;
   assign fire      = b_valid_ff && !stall;
   assign wr_en     = fire && (b_cmd_ff.op == OP_ADD);
   assign load_rsp  = fire && (b_cmd_ff.op == OP_END);

   nfa_wa_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SYM_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_cmd_ff.sym),
      .wr_data (wr_row),
      .rd_addr (cmd_data.sym),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == b_cmd_ff.sym)) begin
         row = lw_data_ff;
      end else if (b_row_valid_ff) begin
         row = ram_rd_data;
      end else begin
         row = '0;
      end
   end

   assign bit_idx = ROW_IDX_W'(int'(b_cmd_ff.from_idx) * NUM_STATES + int'(b_cmd_ff.to_idx));
   assign wr_row  = row | (ROW_W'(1) << bit_idx);

   assign init_set = (int'(cfg.start_state) < NUM_STATES) ?
                     (NUM_STATES'(1) << cfg.start_state) : '0;
   assign cur_set  = fresh_ff ? init_set : active_ff;
   assign cur_view = field_view(cur_set);

   // or of the rows of all active states
   always_comb begin
      next_set = '0;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (cur_set[s]) begin
            next_set = next_set | row[s*NUM_STATES +: NUM_STATES];
         end
      end
   end

   always_comb begin
      active_in    = active_ff;
      fresh_in     = fresh_ff;
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[b_cmd_ff.sym] = 1'b1;
      end
      if (fire && (b_cmd_ff.op == OP_FEED)) begin
         active_in = next_set;
         fresh_in  = 1'b0;
      end else if (load_rsp) begin
         active_in = '0;
         fresh_in  = 1'b1;
      end
      b_valid_in = issue ? 1'b1 : (stall ? b_valid_ff : 1'b0);
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         active_ff    <= '0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         b_valid_ff   <= b_valid_in;
         lw_valid_ff  <= wr_en;
         active_ff    <= active_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_row_valid_ff <= row_valid_ff[cmd_data.sym];
      if (issue) begin
         b_cmd_ff <= cmd_data;
      end
      if (wr_en) begin
         lw_addr_ff <= b_cmd_ff.sym;
         lw_data_ff <= wr_row;
      end
      if (load_rsp) begin
         rsp_data_ff.accepted     <= |(cur_view & cfg.accept_mask);
         rsp_data_ff.final_active <= cur_view;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/nfa_word_acceptor.sv */
// nfa word acceptor top level: csr registers, front end, command queue, back end
// path: an end-of-word request passes the command queue, the execute stage and the response register
// throughput: one request per cycle unless an end-of-word result waits on rsp_ready; the rate is set
//   by the single read port of the edge-row memory, which returns all edge rows of one symbol in one read
// reset: synchronous, active high; the edge store reads as empty at once through
//   one valid flag per symbol row, so no clearing pass and no stall after reset
module nfa_word_acceptor import nfa_wa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   // csr write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers; the user must write them only while the block is idle, the block does not enforce this
   logic [STATE_W-1:0]     start_state_ff;
   logic [FIELD_SET_W-1:0] accept_mask_ff;
   cfg_type                cfg;

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;

   // queue to back end
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         accept_mask_ff <= '0;
      end else if (csr_we) begin
         // indexes outside the register list are ignored
         case (csr_index)
            CSR_START_STATE: start_state_ff <= csr_wdata[STATE_W-1:0];
            CSR_ACCEPT_MASK: accept_mask_ff <= csr_wdata[FIELD_SET_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.start_state = start_state_ff;
   assign cfg.accept_mask = accept_mask_ff;

   // intake: turns requests into commands, drops mode 3 and out-of-range edges
   nfa_wa_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples intake from the back end so each side can stall on its own
   nfa_wa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd_data)
   );

   // row read on issue, then edge insert or subset step or result in the execute stage;
   // the response register lets the next request in while a result waits
   nfa_wa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
